// ===== hw/rtl/dsfs_pkg.sv =====
// Package for the digit scroll/fade sequencer.
// Holds constants and shared types; no dependencies.
package dsfs_pkg;
  localparam int unsigned Digits = 6;
  localparam int unsigned PhaseFull = 100;
  localparam int unsigned ProtectTicks = 5;
  localparam int unsigned SweepEnd = 11;
  localparam int unsigned DigitValues = 10;

  typedef enum logic [1:0] {
    CFG_SCROLLBACK = 2'd0,
    CFG_SCROLL_STEPS = 2'd1,
    CFG_FADE_ENABLE = 2'd2,
    CFG_FADE_STEPS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic       start;
    logic [15:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [15:0] quotient;
  } div_rsp_t;
endpackage

// ===== hw/rtl/dsfs_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on dsfs_pkg.
module dsfs_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsfs_pkg::div_req_t req_i,
  output dsfs_pkg::div_rsp_t rsp_o
);
  import dsfs_pkg::*;

  logic [15:0] quo_q, quo_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [8:0]  trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q, quo_q[15]};
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      den_d = req_i.divisor;
      cnt_d = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 8'(trial - {1'b0, den_q});
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// ===== hw/rtl/digit_scroll_fade_sequencer_unit.sv =====
// When no digit scrolls and no fade runs, a tick passes PREP, DIGIT per digit, FADE, OUT.
// Each scrolling digit adds one shared divider pass (and a second DIGIT visit when its
// scroll starts in that tick); a running fade adds one more pass, except on its last step.
// Ticks are handled one at a time; the input stalls until the result transfers.
// Reset clears current, held and scroll-count digit state; register defaults 0, 4, 0, 20.
// Depends on dsfs_pkg and dsfs_divider.
module digit_scroll_fade_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] target_digits_i,
  input  logic [11:0] digit_modes_i,
  input  logic        blank_all_i,
  input  logic        blink_on_i,
  input  logic        protect_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] shown_digits_o,
  output logic [23:0] switch_digits_o,
  output logic [5:0]  blank_mask_o,
  output logic [7:0]  switch_time_o,
  output logic        protecting_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import dsfs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_DIGIT, ST_SDIV, ST_FADE, ST_FDIV, ST_OUT
  } state_e;

  state_e      state_q;
  logic        sb_en_q, fade_en_q;
  logic [4:0]  ss_cfg_q;
  logic [7:0]  fs_cfg_q;
  logic [3:0]  cur_q [Digits];
  logic [3:0]  held_q [Digits];
  logic [3:0]  tmp_q [Digits];
  logic [7:0]  scnt_q [Digits];
  logic [7:0]  fade_q;
  logic        pmode_q;
  logic [3:0]  pstep_q;
  logic [7:0]  ptick_q;
  logic [2:0]  idx_q;
  logic        rev_q;
  logic [11:0] modes_q;
  logic        blank_all_q, blink_q;
  logic [7:0]  st_q;
  logic [5:0]  mask_q;
  logic [7:0]  fprod_q;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [7:0]  ss, fs;
  logic [3:0]  hd, cd;
  logic [12:0] sprod;
  logic [7:0]  sdec;
  logic [3:0]  pnext;
  logic [3:0]  pval;
  logic [1:0]  typ;
  logic        scroll_load;

  assign ss = (ss_cfg_q == 5'd0) ? 8'd1 : {3'd0, ss_cfg_q};
  assign fs = (fs_cfg_q == 8'd0) ? 8'd1 : fs_cfg_q;
  assign hd = held_q[idx_q];
  assign cd = cur_q[idx_q];
  assign sprod = ({9'd0, cd} + 13'd1) * {5'd0, ss};
  assign sdec = scnt_q[idx_q] - 8'd1;
  assign pnext = pstep_q + 4'd1;
  assign pval = (pnext < 4'd2) ? 4'd0 :
                (pnext >= 4'd12) ? pnext - 4'd12 : pnext - 4'd2;
  assign typ = blank_all_q ? 2'd1 :
               ((modes_q[2*idx_q +: 2] == 2'd2 && !blink_q) ? 2'd1 : modes_q[2*idx_q +: 2]);
  assign scroll_load = !pmode_q && !rev_q && hd != cd && hd == 4'd0 && sb_en_q
                       && scnt_q[idx_q] == 8'd0;

  always_comb begin
    dreq = '0;
    if (state_q == ST_DIGIT && !pmode_q && scnt_q[idx_q] != 8'd0) begin
      dreq.start = 1'b1;
      dreq.dividend = {8'd0, sdec};
      dreq.divisor = ss;
    end else if (state_q == ST_FADE && fade_q > 8'd1) begin
      dreq.start = 1'b1;
      dreq.dividend = 16'(PhaseFull) * {8'd0, fade_q - 8'd1};
      dreq.divisor = fs;
    end
  end

  dsfs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign blank_mask_o = mask_q;
  assign switch_time_o = st_q;
  assign protecting_o = pmode_q;

  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      switch_digits_o[4*i +: 4] = cur_q[i];
      shown_digits_o[4*i +: 4] = (st_q != 8'd0) ? tmp_q[i] : cur_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sb_en_q <= 1'b0;
      fade_en_q <= 1'b0;
      ss_cfg_q <= 5'd4;
      fs_cfg_q <= 8'd20;
      for (int i = 0; i < Digits; i++) begin
        cur_q[i] <= '0;
        held_q[i] <= '0;
        scnt_q[i] <= '0;
      end
      fade_q <= '0;
      pmode_q <= 1'b0;
      pstep_q <= '0;
      ptick_q <= '0;
      idx_q <= '0;
      rev_q <= 1'b0;
      st_q <= '0;
      mask_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cfg_valid_i) begin
            unique case (cfg_idx_e'(cfg_index_i))
              CFG_SCROLLBACK: sb_en_q <= cfg_data_i[0];
              CFG_SCROLL_STEPS: ss_cfg_q <= cfg_data_i[4:0];
              CFG_FADE_ENABLE: fade_en_q <= cfg_data_i[0];
              CFG_FADE_STEPS: fs_cfg_q <= cfg_data_i;
              default: ;
            endcase
          end
          if (in_valid_i) begin
            modes_q <= digit_modes_i;
            blank_all_q <= blank_all_i;
            blink_q <= blink_on_i;
            if (!pmode_q) begin
              for (int i = 0; i < Digits; i++) held_q[i] <= target_digits_i[4*i +: 4];
            end
            if (protect_start_i && !pmode_q && pstep_q == 4'd0) begin
              pmode_q <= 1'b1;
              pstep_q <= 4'd1;
            end
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (pmode_q && pstep_q != 4'd0) begin
            if (ptick_q >= 8'(ProtectTicks)) begin
              ptick_q <= '0;
              for (int i = 0; i < Digits; i++) held_q[i] <= pval;
              if (pnext == 4'(SweepEnd)) begin
                pstep_q <= '0;
                pmode_q <= 1'b0;
              end else begin
                pstep_q <= pnext;
              end
            end else begin
              ptick_q <= ptick_q + 8'd1;
            end
          end
          idx_q <= 3'(Digits - 1);
          mask_q <= '0;
          state_q <= ST_DIGIT;
        end
        ST_DIGIT: begin
          if (typ == 2'd1) mask_q[idx_q] <= 1'b1;
          rev_q <= scroll_load;
          if (pmode_q) begin
            cur_q[idx_q] <= hd;
            tmp_q[idx_q] <= hd;
          end else if (scroll_load) begin
            scnt_q[idx_q] <= (sprod > 13'd255) ? 8'd255 : sprod[7:0];
          end else begin
            if (!rev_q && hd != cd && fade_q == 8'd0 && fade_en_q) fade_q <= fs;
            else if (!rev_q && hd != cd && fade_q == 8'd0 && scnt_q[idx_q] == 8'd0)
              cur_q[idx_q] <= hd;
            if (scnt_q[idx_q] != 8'd0) begin
              scnt_q[idx_q] <= sdec;
            end else begin
              tmp_q[idx_q] <= hd;
            end
          end
          if (!pmode_q && scnt_q[idx_q] != 8'd0) begin
            state_q <= ST_SDIV;
          end else if (scroll_load) begin
            // Scroll count was just loaded; revisit this digit to count it down.
            state_q <= ST_DIGIT;
          end else if (idx_q == 3'd0) begin
            state_q <= ST_FADE;
          end else begin
            idx_q <= idx_q - 3'd1;
          end
        end
        ST_SDIV: begin
          if (drsp.done) begin
            cur_q[idx_q] <= (drsp.quotient > 16'd15) ? 4'd15 : drsp.quotient[3:0];
            tmp_q[idx_q] <= (drsp.quotient > 16'd15) ? 4'd15 : drsp.quotient[3:0];
            if (idx_q == 3'd0) state_q <= ST_FADE;
            else begin
              idx_q <= idx_q - 3'd1;
              state_q <= ST_DIGIT;
            end
          end
        end
        ST_FADE: begin
          st_q <= '0;
          fprod_q <= fade_q - 8'd1;
          if (fade_q == 8'd1) begin
            fade_q <= '0;
            for (int i = 0; i < Digits; i++) begin
              if (scnt_q[i] == 8'd0) cur_q[i] <= held_q[i];
            end
            state_q <= ST_OUT;
          end else if (fade_q != 8'd0) begin
            fade_q <= fade_q - 8'd1;
            state_q <= ST_FDIV;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_FDIV: begin
          if (drsp.done) begin
            if (fprod_q <= fs) st_q <= 8'(16'(PhaseFull) - drsp.quotient);
            else st_q <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
